// ----- sv/pfa_pkg.sv -----
// Package for the packet frame assembler: sizes, codes and the records
// passed between the front, the queue and the back. No dependencies.
package pfa_pkg;

    localparam int SLOTS       = 8;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LAST_PACKET = 127;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [39:0] SIG_VALUE     = 40'hf0f1f2f3f4;
    localparam logic [13:0] RESET_MIN_LEN = 14'd384;
    localparam logic [7:0]  LAST_IDX      = 8'(LAST_PACKET);

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_FORCED   = 3'd2,
        ST_SHORT    = 3'd3,
        ST_BAD_SIG  = 3'd4,
        ST_HALTED   = 3'd5,
        ST_RELEASED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        REG_MIN_BYTES = 2'd0,
        REG_CHECK_SIG = 2'd1,
        REG_CHECK_PI  = 2'd2,
        REG_CHECK_FI  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [13:0] min_bytes;
        logic        check_sig;
        logic        check_pi;
        logic        check_fi;
    } t_cfg;

    // classified item, as the front hands it to the back
    typedef struct packed {
        logic        is_release;
        logic [2:0]  rel;
        logic        rel_ok;
        logic        is_short;
        logic        bad_sig;
        logic        is_last;
        logic [7:0]  pidx;
        logic [15:0] fi;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [2:0]  slot;
        logic [7:0]  pos;
        logic [15:0] fi;
        logic        done;
        logic        damaged;
        logic        missed;
        logic        mismatch;
        logic        halted;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic stopped;
    } t_back_stat;

endpackage

// ----- sv/pfa_in_if.sv -----
// Input channel of the packet frame assembler: valid, ready and the item fields.
// No dependencies.
interface pfa_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [13:0] packet_bytes;
    logic [39:0] signature;
    logic [7:0]  packet_index;
    logic [15:0] frame_index_raw;
    logic [2:0]  release_slot;

    modport source (
        output valid, req_type, packet_bytes, signature, packet_index,
               frame_index_raw, release_slot,
        input  ready
    );
    modport sink (
        input  valid, req_type, packet_bytes, signature, packet_index,
               frame_index_raw, release_slot,
        output ready
    );
endinterface

// ----- sv/pfa_out_if.sv -----
// Result channel of the packet frame assembler: valid, ready and the result fields.
// No dependencies.
interface pfa_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [7:0]  packet_position;
    logic [15:0] frame_index;
    logic        frame_done;
    logic        frame_damaged;
    logic        missed_trigger;
    logic        frame_index_mismatch;
    logic        halted;

    modport source (
        output valid, status, slot, packet_position, frame_index, frame_done,
               frame_damaged, missed_trigger, frame_index_mismatch, halted,
        input  ready
    );
    modport sink (
        input  valid, status, slot, packet_position, frame_index, frame_done,
               frame_damaged, missed_trigger, frame_index_mismatch, halted,
        output ready
    );
endinterface

// ----- sv/packet_frame_assembler.sv -----
// Top level of the packet frame assembler: configuration registers, front,
// queue and back. Depends on pfa_pkg, pfa_in_if, pfa_out_if and the pfa_ modules.

// The block takes one item per clock when nothing stalls: a camera packet header or a slot release.
// Every item gives exactly one result, in order, presented after the front register
// (loaded at the accepting edge), a queue entry and the result register. The sustained
// rate is one item per cycle when the output does not stall, set by the back stage,
// which updates the ring state (slot full bits, current slot, packet count, damage
// mark) as it takes each item. A two-entry queue parts front and back, so a short
// stall at the output does not close the input at once. Short or badly signed
// packets are dropped with their own status; the packet with the last index closes
// the frame and moves to the next ring slot, and halts the block for good if that
// slot is still full. Releases keep working after a halt. Write configuration only
// while no item is in flight.
module packet_frame_assembler
    import pfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [13:0] i_cfg_data,
    pfa_in_if.sink      i_in,
    pfa_out_if.source   o_out
);

    t_cfg       r_cfg;
    logic       f_valid;
    logic       q_ready;
    t_item      f_item;
    logic       q_valid;
    logic       b_ready;
    t_item      q_item;
    t_q_stat    q_stat;
    t_result    b_res;
    t_back_stat b_stat;

    // configuration writes; hold each value until rewritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_bytes <= RESET_MIN_LEN;
            r_cfg.check_sig <= 1'b1;
            r_cfg.check_pi  <= 1'b1;
            r_cfg.check_fi  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_BYTES: r_cfg.min_bytes <= i_cfg_data;
                REG_CHECK_SIG: r_cfg.check_sig <= i_cfg_data[0];
                REG_CHECK_PI:  r_cfg.check_pi  <= i_cfg_data[0];
                REG_CHECK_FI:  r_cfg.check_fi  <= i_cfg_data[0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // classify: length, signature, last index, byte swap
    pfa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (q_ready),
        .o_item  (f_item)
    );

    // decouple front and back
    pfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (b_ready),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // apply items to the frame ring and register results
    pfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .o_ready     (b_ready),
        .i_item      (q_item),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_res       (b_res),
        .o_stat      (b_stat)
    );

    assign o_out.status               = b_res.status;
    assign o_out.slot                 = b_res.slot;
    assign o_out.packet_position      = b_res.pos;
    assign o_out.frame_index          = b_res.fi;
    assign o_out.frame_done           = b_res.done;
    assign o_out.frame_damaged        = b_res.damaged;
    assign o_out.missed_trigger       = b_res.missed;
    assign o_out.frame_index_mismatch = b_res.mismatch;
    assign o_out.halted               = b_res.halted;

`ifndef NO_ASSERTIONS
    // the queue can never be full and empty at once
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    // a halt is permanent
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.stopped |=> b_stat.stopped)
        else $error("halt cleared");

    // a halted result is only shown once the back has stopped
    a_halt_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_HALTED)) |-> b_stat.stopped)
        else $error("halted result without halt");
`endif

endmodule

// ----- sv/pfa_front.sv -----
// Front stage: accept an item, run the stateless checks and register the record.
// Depends on pfa_pkg and pfa_in_if.
module pfa_front
    import pfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    pfa_in_if.sink      i_in,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_comb begin
        n_item.is_release = i_in.req_type;
        n_item.rel        = i_in.release_slot;
        n_item.rel_ok     = 32'(i_in.release_slot) < SLOTS;
        n_item.is_short   = i_in.packet_bytes < i_cfg.min_bytes;
        n_item.bad_sig    = i_cfg.check_sig && (i_in.signature != SIG_VALUE);
        n_item.is_last    = i_in.packet_index == LAST_IDX;
        n_item.pidx       = i_in.packet_index;
        // swap bytes of the frame index
        n_item.fi         = {i_in.frame_index_raw[7:0], i_in.frame_index_raw[15:8]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- sv/pfa_queue.sv -----
// Short queue of classified items between front and back.
// Depends on pfa_pkg.
module pfa_queue
    import pfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_ready      = 32'(r_count) < QDEPTH;
    assign o_valid      = r_count != '0;
    assign o_item       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_stat.full  = !o_ready;
    assign o_stat.empty = !o_valid;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (32'(p) == QDEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= bump(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= bump(r_rd_ptr);
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- sv/pfa_back.sv -----
// Back stage: apply each classified item to the frame ring state and register
// the result. Depends on pfa_pkg.
module pfa_back
    import pfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_result    o_res,
    output t_back_stat o_stat
);

    logic [SLOTS-1:0]  r_full, n_full;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [7:0]        r_pif, n_pif;
    logic              r_dmg, n_dmg;
    logic [15:0]       r_ffi, n_ffi;
    logic              r_stopped, n_stopped;
    logic              r_out_valid;
    t_result           r_res, n_res;

    logic [SLOT_W-1:0] nxt;
    logic              dmg_now;
    logic              take;

    assign o_ready        = !r_out_valid || i_out_ready;
    assign take           = i_valid && o_ready;
    assign o_out_valid    = r_out_valid;
    assign o_res          = r_res;
    assign o_stat.stopped = r_stopped;

    assign nxt     = (32'(r_cur) == SLOTS - 1) ? '0 : r_cur + 1'b1;
    assign dmg_now = r_dmg || (i_cfg.check_pi && (i_item.pidx != r_pif));

    always_comb begin
        n_full    = r_full;
        n_cur     = r_cur;
        n_pif     = r_pif;
        n_dmg     = r_dmg;
        n_ffi     = r_ffi;
        n_stopped = r_stopped;
        n_res     = '0;
        n_res.slot = 3'(r_cur);

        if (i_item.is_release) begin
            if (i_item.rel_ok) n_full[SLOT_W'(i_item.rel)] = 1'b0;
            n_res.status = ST_RELEASED;
            n_res.slot   = i_item.rel;
            n_res.halted = r_stopped;
        end else if (r_stopped) begin
            n_res.status = ST_HALTED;
            n_res.halted = 1'b1;
        end else if (i_item.is_short) begin
            n_res.status = ST_SHORT;
        end else if (i_item.bad_sig) begin
            n_res.status = ST_BAD_SIG;
        end else begin
            if (r_pif == '0) n_ffi = i_item.fi;
            n_res.mismatch = i_cfg.check_fi && (r_pif != '0) && (r_ffi != i_item.fi);
            n_res.pos      = r_pif;
            n_res.fi       = i_item.fi;
            n_res.damaged  = dmg_now;
            n_dmg          = dmg_now;
            if (i_item.is_last) begin
                n_res.status = ST_COMPLETE;
                n_res.done   = 1'b1;
                if (r_full[nxt]) begin
                    n_stopped    = 1'b1;
                    n_res.halted = 1'b1;
                end else begin
                    n_cur       = nxt;
                    n_pif       = '0;
                    n_dmg       = 1'b0;
                    n_full[nxt] = 1'b1;
                end
            end else if (r_pif >= LAST_IDX) begin
                // count overflow: close the frame without its last packet
                n_res.status = ST_FORCED;
                n_res.done   = 1'b1;
                n_res.missed = 1'b1;
                n_cur        = nxt;
                n_pif        = '0;
                n_dmg        = 1'b0;
                n_full[nxt]  = 1'b1;
                n_ffi        = '0;
            end else begin
                n_res.status = ST_STORED;
                n_pif        = r_pif + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= SLOTS'(1);
            r_cur       <= '0;
            r_pif       <= '0;
            r_dmg       <= 1'b0;
            r_ffi       <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_out_valid <= i_valid;
            if (take) begin
                r_full    <= n_full;
                r_cur     <= n_cur;
                r_pif     <= n_pif;
                r_dmg     <= n_dmg;
                r_ffi     <= n_ffi;
                r_stopped <= n_stopped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

endmodule

// ----- tb/tb_packet_frame_assembler.sv -----
// Self-checking testbench for packet_frame_assembler: drives packet headers and
// slot releases, predicts every result and compares it field by field.
// Depends on pfa_pkg, pfa_in_if, pfa_out_if and the packet_frame_assembler RTL.
`timescale 1ns / 1ps

module tb_packet_frame_assembler;
    import pfa_pkg::*;

    localparam int MAX_BYTES = 9008;  // longest packet the link delivers
    localparam int SETTLE    = 8;     // cycles of quiet before register writes and at the end

    // One input item as the sender presents it.
    typedef struct packed {
        logic        is_release;
        logic [13:0] bytes;
        logic [39:0] sig;
        logic [7:0]  pidx;
        logic [15:0] raw;
        logic [2:0]  rel;
    } t_rx_item;

    // Tracks the frame ring the way the block should, and holds the results it owes.
    class frame_ring_ledger;
        t_cfg              cfg;
        bit                slot_full[SLOTS];
        logic [SLOT_W-1:0] cur_slot;
        logic [7:0]        pkt_count;
        bit                damaged;
        logic [15:0]       first_fi;
        bit                stopped;
        t_result           owed[$];
        int                status_seen[8];
        int                checked;
        int                errors;

        function new();
            cfg = '{min_bytes: RESET_MIN_LEN, check_sig: 1'b1, check_pi: 1'b1,
                    check_fi: 1'b1};
            foreach (slot_full[s]) slot_full[s] = (s == 0);
            foreach (status_seen[k]) status_seen[k] = 0;
            cur_slot  = '0;
            pkt_count = '0;
            damaged   = 1'b0;
            first_fi  = '0;
            stopped   = 1'b0;
            checked   = 0;
            errors    = 0;
        endfunction

        function int next_slot();
            return (int'(cur_slot) + 1) % SLOTS;
        endfunction

        function void open_frame(int s);
            cur_slot       = s[SLOT_W-1:0];
            pkt_count      = '0;
            damaged        = 1'b0;
            slot_full[s]   = 1'b1;
        endfunction

        // Work out the result of one item and advance the ring state.
        function t_result assemble(t_rx_item it);
            t_result     res;
            logic [15:0] fi;
            logic [7:0]  pos;
            int          nxt;
            res = '0;
            if (it.is_release) begin
                // every 3-bit slot number names a real slot with eight slots
                slot_full[it.rel] = 1'b0;
                res.status = ST_RELEASED;
                res.slot   = it.rel;
                res.halted = stopped;
                return res;
            end
            res.slot = cur_slot;
            if (stopped) begin
                res.status = ST_HALTED;
                res.halted = 1'b1;
                return res;
            end
            // length goes first, then the signature
            if (it.bytes < cfg.min_bytes) begin
                res.status = ST_SHORT;
                return res;
            end
            if (cfg.check_sig && it.sig != SIG_VALUE) begin
                res.status = ST_BAD_SIG;
                return res;
            end
            fi  = {it.raw[7:0], it.raw[15:8]};
            pos = pkt_count;
            if (pos == 0) first_fi = fi;
            if (cfg.check_fi && pos != 0 && first_fi != fi) res.mismatch = 1'b1;
            if (cfg.check_pi && it.pidx != pos) damaged = 1'b1;
            res.pos     = pos;
            res.fi      = fi;
            res.damaged = damaged;
            if (it.pidx == LAST_IDX) begin
                res.status = ST_COMPLETE;
                res.done   = 1'b1;
                nxt = next_slot();
                if (slot_full[nxt]) begin
                    // frame still closes, but the ring stops here for good
                    stopped    = 1'b1;
                    res.halted = 1'b1;
                end else begin
                    open_frame(nxt);
                end
                return res;
            end
            if (pos >= LAST_IDX) begin
                // count overflow: take the next slot whether it is free or not
                res.status = ST_FORCED;
                res.done   = 1'b1;
                res.missed = 1'b1;
                open_frame(next_slot());
                first_fi = '0;
                return res;
            end
            pkt_count  = pos + 8'd1;
            res.status = ST_STORED;
            return res;
        endfunction

        function void take_item(t_rx_item it);
            t_result res;
            res = assemble(it);
            owed.push_back(res);
            status_seen[res.status]++;
        endfunction

        function void check_field(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp) begin
                $error("%s: expected %0h, got %0h", name, exp, act);
                errors++;
            end
        endfunction

        function void match_result(t_result got);
            t_result exp;
            checked++;
            if (owed.size() == 0) begin
                $error("result with no item outstanding: status %0d slot %0d",
                       got.status, got.slot);
                errors++;
                return;
            end
            exp = owed.pop_front();
            check_field("status", exp.status, got.status);
            check_field("slot", exp.slot, got.slot);
            check_field("packet_position", exp.pos, got.pos);
            check_field("frame_index", exp.fi, got.fi);
            check_field("frame_done", exp.done, got.done);
            check_field("frame_damaged", exp.damaged, got.damaged);
            check_field("missed_trigger", exp.missed, got.missed);
            check_field("frame_index_mismatch", exp.mismatch, got.mismatch);
            check_field("halted", exp.halted, got.halted);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [13:0] i_cfg_data;

    pfa_in_if  in_ch ();
    pfa_out_if out_ch ();

    packet_frame_assembler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    frame_ring_ledger ledger = new();

    bit steady;      // both sides run without gaps while set
    bit allow_halt;  // stop feeding releases ahead of a closing packet
    int sent;        // items accepted so far
    int stall_left;  // remaining cycles the result side holds ready low

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run is far longer than the slowest legal pass; end it if it hangs.
    initial begin
        #5_000_000;
        $display("[packet_frame_assembler] ERROR");
        $finish;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic logic [39:0] rand_sig();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic t_rx_item mk(logic req, logic [13:0] bytes, logic [39:0] sig,
                                    logic [7:0] pidx, logic [15:0] raw, logic [2:0] rel);
        return '{is_release: req, bytes: bytes, sig: sig, pidx: pidx, raw: raw, rel: rel};
    endfunction

    // Well-formed header: long enough and correctly signed for the current settings.
    function automatic t_rx_item packet(logic [7:0] pidx, logic [15:0] raw);
        return mk(1'b0, 14'($urandom_range(int'(ledger.cfg.min_bytes), MAX_BYTES)),
                  SIG_VALUE, pidx, raw, 3'($urandom_range(0, 7)));
    endfunction

    // Release of a slot; the unused header fields carry random junk.
    function automatic t_rx_item release_of(int s);
        return mk(1'b1, 14'($urandom_range(0, MAX_BYTES)), rand_sig(),
                  8'($urandom_range(0, 255)), 16'($urandom), 3'(s));
    endfunction

    // Present one item and hold it until the block takes it. A zero gap keeps
    // valid high straight into the next item.
    task automatic send(t_rx_item it);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.req_type        <= it.is_release;
        in_ch.packet_bytes    <= it.bytes;
        in_ch.signature       <= it.sig;
        in_ch.packet_index    <= it.pidx;
        in_ch.frame_index_raw <= it.raw;
        in_ch.release_slot    <= it.rel;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        ledger.take_item(it);
        sent++;
        if ($urandom_range(0, 47) == 0) steady = !steady;
    endtask

    // Send a header; ahead of a closing packet, free the next slot like a
    // consumer would, unless the run is meant to halt.
    task automatic send_pkt(t_rx_item it);
        if (!allow_halt && !ledger.stopped && it.pidx == LAST_IDX &&
            ledger.slot_full[ledger.next_slot()])
            send(release_of(ledger.next_slot()));
        send(it);
    endtask

    // Short frame with in-order indices and one frame index, now and then
    // spoiled by a short packet, a broken signature, a skipped index or a
    // foreign frame index. Picks up a partly filled frame where it stands.
    task automatic frame_burst();
        int          len;
        logic [15:0] raw;
        t_rx_item    it;
        len = $urandom_range(1, 10);
        raw = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            it = packet((i == len - 1) ? LAST_IDX : ledger.pkt_count, raw);
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        if (ledger.cfg.min_bytes != 0)
                            it.bytes = 14'($urandom_range(0, int'(ledger.cfg.min_bytes) - 1));
                    end
                    1: it.sig  = it.sig ^ (40'd1 << $urandom_range(0, 39));
                    2: it.pidx = it.pidx + 8'($urandom_range(1, 3));
                    default: it.raw = 16'($urandom);
                endcase
            end
            if ($urandom_range(0, 7) == 0) send(release_of($urandom_range(0, SLOTS - 1)));
            send_pkt(it);
        end
    endtask

    // Header with every field random.
    task automatic noise();
        send_pkt(mk(1'b0, 14'($urandom_range(0, MAX_BYTES)),
                    ($urandom_range(0, 1) != 0) ? SIG_VALUE : rand_sig(),
                    8'($urandom_range(0, 255)), 16'($urandom), 3'($urandom_range(0, 7))));
    endtask

    // Fill the frame to its last position without the closing index, then
    // overflow it so the block has to force it out.
    task automatic long_frame();
        logic [15:0] raw;
        raw = 16'($urandom);
        while (ledger.pkt_count < LAST_IDX && !ledger.stopped)
            send_pkt(packet(ledger.pkt_count, raw));
        send_pkt(packet(8'($urandom_range(128, 255)), raw));
    endtask

    // Drop valid and hold until every owed result is back.
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (ledger.owed.size() != 0);
    endtask

    // Write all four registers back to back once the block is idle.
    task automatic reconfigure(logic [13:0] min_bytes, bit chk_sig, bit chk_pi, bit chk_fi);
        pause_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MIN_BYTES;
        i_cfg_data <= min_bytes;
        @(posedge i_clk);
        i_cfg_idx  <= REG_CHECK_SIG;
        i_cfg_data <= 14'(chk_sig);
        @(posedge i_clk);
        i_cfg_idx  <= REG_CHECK_PI;
        i_cfg_data <= 14'(chk_pi);
        @(posedge i_clk);
        i_cfg_idx  <= REG_CHECK_FI;
        i_cfg_data <= 14'(chk_fi);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ledger.cfg = '{min_bytes: min_bytes, check_sig: chk_sig, check_pi: chk_pi,
                       check_fi: chk_fi};
    endtask

    // Mostly well-formed frames with noise and stray releases; one drain in
    // the middle, and an overflowing frame where asked.
    task automatic run_phase(int n, bit with_long);
        int start;
        bit paused;
        bit long_done;
        start     = sent;
        paused    = 1'b0;
        long_done = !with_long;
        while (sent - start < n) begin
            if (!paused && sent - start >= n / 2) begin
                pause_until_drained();
                paused = 1'b1;
            end
            if (!long_done && sent - start >= n / 3) begin
                long_frame();
                long_done = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1:    noise();
                    2:       send(release_of($urandom_range(0, SLOTS - 1)));
                    default: frame_burst();
                endcase
            end
        end
    endtask

    // Stop releasing, close frames until the ring runs into a full slot,
    // then show that headers bounce and releases still work.
    task automatic run_halt();
        logic [15:0] raw;
        allow_halt = 1'b1;
        for (int k = 0; k < 4 * SLOTS && !ledger.stopped; k++) begin
            raw = 16'($urandom);
            repeat ($urandom_range(0, 2)) send(packet(ledger.pkt_count, raw));
            send(packet(LAST_IDX, raw));
        end
        repeat (24) begin
            if ($urandom_range(0, 2) != 0) noise();
            else send(release_of($urandom_range(0, SLOTS - 1)));
        end
    endtask

    // Result side: check each accepted result, then pick ready for the next
    // cycle with random stalls.
    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.status   = t_status'(out_ch.status);
                got.slot     = out_ch.slot;
                got.pos      = out_ch.packet_position;
                got.fi       = out_ch.frame_index;
                got.done     = out_ch.frame_done;
                got.damaged  = out_ch.frame_damaged;
                got.missed   = out_ch.missed_trigger;
                got.mismatch = out_ch.frame_index_mismatch;
                got.halted   = out_ch.halted;
                ledger.match_result(got);
            end
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = REG_MIN_BYTES;
        i_cfg_data            = '0;
        in_ch.valid           = 1'b0;
        in_ch.req_type        = 1'b0;
        in_ch.packet_bytes    = '0;
        in_ch.signature       = '0;
        in_ch.packet_index    = '0;
        in_ch.frame_index_raw = '0;
        in_ch.release_slot    = '0;
        steady                = 1'b0;
        allow_halt            = 1'b0;
        sent                  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: minimum 384 bytes, all checks on.
        // Drops: empty and one-short packets, then wrong signatures at both
        // length extremes and with only the last byte off.
        send(mk(1'b0, 14'd0, SIG_VALUE, 8'd0, 16'h0000, 3'd0));
        send(mk(1'b0, 14'd383, SIG_VALUE, 8'd0, 16'h0000, 3'd0));
        send(mk(1'b0, 14'd384, 40'h0, 8'd0, 16'h3412, 3'd7));
        send(mk(1'b0, 14'(MAX_BYTES), 40'hffffffffff, 8'hff, 16'hffff, 3'd7));
        send(mk(1'b0, 14'd384, 40'hf0f1f2f3f5, 8'd0, 16'h3412, 3'd0));
        // Frame into slot 0: two in order, a skipped index with a foreign frame
        // index, then the closing packet moves to slot 1.
        send(mk(1'b0, 14'd384, SIG_VALUE, 8'd0, 16'h3412, 3'd0));
        send(mk(1'b0, 14'(MAX_BYTES), SIG_VALUE, 8'd1, 16'h3412, 3'd0));
        send(mk(1'b0, 14'd500, SIG_VALUE, 8'd3, 16'h0000, 3'd0));
        send(mk(1'b0, 14'd384, SIG_VALUE, LAST_IDX, 16'h3412, 3'd0));
        // Releases: the finished slot, an empty one, and the slot being filled.
        send(release_of(0));
        send(release_of(SLOTS - 1));
        send(release_of(1));
        // Two-packet frame with an all-ones frame index; the closing index
        // comes at position one and marks the frame damaged.
        send(mk(1'b0, 14'd1000, SIG_VALUE, 8'd0, 16'hffff, 3'd0));
        send(mk(1'b0, 14'd1000, SIG_VALUE, LAST_IDX, 16'hffff, 3'd0));
        send(release_of(2));

        // Everything accepted, no checks: overflow a frame on purpose.
        reconfigure(14'd0, 1'b0, 1'b0, 1'b0);
        run_phase(200, 1'b1);
        // Only full-size packets pass; frame index check off.
        reconfigure(14'(MAX_BYTES), 1'b1, 1'b1, 1'b0);
        run_phase(170, 1'b0);
        // Random middle setting, with another overflow.
        reconfigure(14'($urandom_range(0, 700)), 1'($urandom), 1'($urandom), 1'($urandom));
        run_phase(200, 1'b1);
        reconfigure(RESET_MIN_LEN, 1'b1, 1'b0, 1'b1);
        run_phase(170, 1'b0);
        // Header-only minimum, all checks on, then drive the ring into a halt.
        reconfigure(14'd8, 1'b1, 1'b1, 1'b1);
        run_phase(170, 1'b0);
        run_halt();

        pause_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d items and %0d results: %0d stored, %0d complete, %0d forced,",
                 sent, ledger.checked, ledger.status_seen[ST_STORED],
                 ledger.status_seen[ST_COMPLETE], ledger.status_seen[ST_FORCED]);
        $display("  %0d short, %0d bad signature, %0d after halt, %0d releases; halt reached: %0d",
                 ledger.status_seen[ST_SHORT], ledger.status_seen[ST_BAD_SIG],
                 ledger.status_seen[ST_HALTED], ledger.status_seen[ST_RELEASED],
                 ledger.stopped);
        if (ledger.errors == 0)
            $display("[packet_frame_assembler] OK");
        else
            $display("[packet_frame_assembler] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pfa_pkg.sv
sv/pfa_in_if.sv
sv/pfa_out_if.sv
sv/pfa_front.sv
sv/pfa_queue.sv
sv/pfa_back.sv
sv/packet_frame_assembler.sv
tb/tb_packet_frame_assembler.sv
